// ===== rtl/sfr_pkg.sv =====
// ============================================================================
// sfr_pkg
// Shared constants and types for the framed byte receiver: header bytes,
// result status codes and the command/status bundles between the controller
// and the datapath.
// ============================================================================
package sfr_pkg;

    // Default largest payload of one frame.
    localparam int MAX_PAYLOAD_DEF = 32;

    // Header bytes that open a frame.
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_BUSY     = 2'd0;
    localparam t_status ST_OK       = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;
    localparam t_status ST_BADSUM   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    sum_hdr;        // Restart the checksum with the first header byte.
        logic    sum_add;        // Add the input byte to the checksum.
        logic    sum_clear;      // Clear the checksum.
        logic    cmd_load;       // Hold the command byte.
        logic    len_load;       // Hold the length byte and rewind the fill index.
        logic    fill_write;     // Store one payload byte and advance the fill index.
        logic    err_inc;        // Count a rejected frame.
        logic    valid_inc;      // Count an accepted frame.
        logic    out_load_stat;  // Load a status-only result into the output register.
        t_status stat_code;      // Status of that result.
        logic    ok_empty;       // That result reports a good empty frame.
        logic    emit_start;     // Rewind the emission index.
        logic    out_load_byte;  // Load one payload byte result.
        logic    emit_next;      // Advance the emission index.
    } t_sfr_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_hdr1;    // Input byte is the first header byte.
        logic is_hdr2;    // Input byte is the second header byte.
        logic len_over;   // Input byte exceeds the largest payload.
        logic len_zero;   // Input byte is zero.
        logic held_zero;  // Held frame length is zero.
        logic fill_last;  // This payload byte completes the payload.
        logic sum_ok;     // Input byte equals the running checksum.
        logic out_free;   // Output register can take a new result this cycle.
        logic emit_last;  // Current emission index is the final payload byte.
    } t_sfr_stat;

endpackage : sfr_pkg

// ===== rtl/sfr_ctrl.sv =====
// ============================================================================
// sfr_ctrl
// Frame parser controller: walks the header, command, length, payload and
// checksum phases, then sequences the emission of a good frame's payload.
// ============================================================================
module sfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sfr_pkg::t_sfr_stat i_stat,
    output sfr_pkg::t_sfr_cmd  o_cmd
);
    import sfr_pkg::*;

    typedef enum logic [7:0] {
        S_HUNT    = 8'b0000_0001,
        S_SECOND  = 8'b0000_0010,
        S_COMMAND = 8'b0000_0100,
        S_LENGTH  = 8'b0000_1000,
        S_PAYLOAD = 8'b0001_0000,
        S_CHECK   = 8'b0010_0000,
        S_FETCH   = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_parse;
    logic   w_acc;

    assign w_parse    = (r_state != S_FETCH) && (r_state != S_EMIT);
    assign o_in_ready = w_parse && i_stat.out_free;
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (w_acc) begin
            // Every accepted byte gives one status result unless it starts
            // the emission of a non-empty good frame.
            o_cmd.out_load_stat = 1'b1;
            o_cmd.stat_code     = ST_BUSY;
        end
        unique case (r_state)
            S_HUNT: begin
                if (w_acc && i_stat.is_hdr1) begin
                    o_cmd.sum_hdr = 1'b1;
                    n_state       = S_SECOND;
                end
            end
            S_SECOND: begin
                if (w_acc) begin
                    if (i_stat.is_hdr2) begin
                        o_cmd.sum_add = 1'b1;
                        n_state       = S_COMMAND;
                    end else if (i_stat.is_hdr1) begin
                        o_cmd.sum_hdr = 1'b1;
                        n_state       = S_SECOND;
                    end else begin
                        o_cmd.sum_clear = 1'b1;
                        n_state         = S_HUNT;
                    end
                end
            end
            S_COMMAND: begin
                if (w_acc) begin
                    o_cmd.cmd_load = 1'b1;
                    o_cmd.sum_add  = 1'b1;
                    n_state        = S_LENGTH;
                end
            end
            S_LENGTH: begin
                if (w_acc) begin
                    if (i_stat.len_over) begin
                        o_cmd.err_inc   = 1'b1;
                        o_cmd.stat_code = ST_OVERFLOW;
                        n_state         = S_HUNT;
                    end else begin
                        o_cmd.len_load = 1'b1;
                        o_cmd.sum_add  = 1'b1;
                        n_state        = i_stat.len_zero ? S_CHECK : S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD: begin
                if (w_acc) begin
                    o_cmd.fill_write = 1'b1;
                    o_cmd.sum_add    = 1'b1;
                    if (i_stat.fill_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_acc) begin
                    n_state = S_HUNT;
                    if (!i_stat.sum_ok) begin
                        o_cmd.err_inc   = 1'b1;
                        o_cmd.stat_code = ST_BADSUM;
                    end else begin
                        o_cmd.valid_inc = 1'b1;
                        if (i_stat.held_zero) begin
                            o_cmd.stat_code = ST_OK;
                            o_cmd.ok_empty  = 1'b1;
                        end else begin
                            o_cmd.out_load_stat = 1'b0;
                            o_cmd.emit_start    = 1'b1;
                            n_state             = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load_byte = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule : sfr_ctrl

// ===== rtl/sfr_datapath.sv =====
// ============================================================================
// sfr_datapath
// Frame receiver datapath: checksum, held command and length, payload memory,
// frame counters and the output result register.
// ============================================================================
module sfr_datapath #(
    parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_out_ready,
    input  sfr_pkg::t_sfr_cmd  i_cmd,
    output sfr_pkg::t_sfr_stat o_stat,
    output logic               o_out_valid,
    output logic [63:0]        o_out_data,
    output logic [2:0]         o_out_user,
    output logic               o_out_last
);
    import sfr_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]  r_sum;
    logic [7:0]  r_cmd;
    logic [6:0]  r_len;
    logic [6:0]  r_fill;
    logic [5:0]  r_emit_idx;
    logic [15:0] r_err_cnt;
    logic [15:0] r_vld_cnt;
    logic [15:0] n_err_cnt;
    logic [15:0] n_vld_cnt;
    logic [7:0]  r_mem [MAX_PAYLOAD];
    logic [7:0]  r_rd_data;

    logic        r_out_valid;
    t_status     r_out_status;
    logic [7:0]  r_out_cmd;
    logic [6:0]  r_out_len;
    logic        r_out_has;
    logic [7:0]  r_out_byte;
    logic [5:0]  r_out_idx;
    logic        r_out_last;
    logic [15:0] r_out_err;
    logic [15:0] r_out_vld;

    logic [6:0]  w_fill_inc;
    logic [6:0]  w_emit_inc;

    assign w_fill_inc = r_fill + 7'd1;
    assign w_emit_inc = {1'b0, r_emit_idx} + 7'd1;
    assign n_err_cnt  = i_cmd.err_inc   ? r_err_cnt + 16'd1 : r_err_cnt;
    assign n_vld_cnt  = i_cmd.valid_inc ? r_vld_cnt + 16'd1 : r_vld_cnt;

    always_comb begin
        o_stat           = '0;
        o_stat.is_hdr1   = (i_rx_byte == HDR_FIRST);
        o_stat.is_hdr2   = (i_rx_byte == HDR_SECOND);
        o_stat.len_over  = (i_rx_byte > 8'(MAX_PAYLOAD));
        o_stat.len_zero  = (i_rx_byte == 8'd0);
        o_stat.held_zero = (r_len == 7'd0);
        o_stat.fill_last = (w_fill_inc >= r_len);
        o_stat.sum_ok    = (i_rx_byte == r_sum);
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.emit_last = (w_emit_inc == r_len);
    end

    // Parser state and frame counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_cmd      <= '0;
            r_len      <= '0;
            r_fill     <= '0;
            r_emit_idx <= '0;
            r_err_cnt  <= '0;
            r_vld_cnt  <= '0;
        end else begin
            if (i_cmd.sum_hdr) begin
                r_sum <= HDR_FIRST;
            end else if (i_cmd.sum_add) begin
                r_sum <= r_sum + i_rx_byte;
            end else if (i_cmd.sum_clear) begin
                r_sum <= '0;
            end
            if (i_cmd.cmd_load) begin
                r_cmd <= i_rx_byte;
            end
            if (i_cmd.len_load) begin
                r_len  <= i_rx_byte[6:0];
                r_fill <= '0;
            end else if (i_cmd.fill_write) begin
                r_fill <= w_fill_inc;
            end
            if (i_cmd.emit_start) begin
                r_emit_idx <= '0;
            end else if (i_cmd.emit_next) begin
                r_emit_idx <= w_emit_inc[5:0];
            end
            r_err_cnt <= n_err_cnt;
            r_vld_cnt <= n_vld_cnt;
        end
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_write && (r_fill < 7'(MAX_PAYLOAD))) begin
            r_mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_mem[r_emit_idx[AW-1:0]];
    end

    // Output result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_stat || i_cmd.out_load_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_stat) begin
            r_out_status <= i_cmd.stat_code;
            r_out_cmd    <= i_cmd.ok_empty ? r_cmd : 8'd0;
            r_out_len    <= '0;
            r_out_has    <= 1'b0;
            r_out_byte   <= '0;
            r_out_idx    <= '0;
            r_out_last   <= 1'b1;
            r_out_err    <= n_err_cnt;
            r_out_vld    <= n_vld_cnt;
        end else if (i_cmd.out_load_byte) begin
            r_out_status <= ST_OK;
            r_out_cmd    <= r_cmd;
            r_out_len    <= r_len;
            r_out_has    <= 1'b1;
            r_out_byte   <= r_rd_data;
            r_out_idx    <= r_emit_idx;
            r_out_last   <= o_stat.emit_last;
            r_out_err    <= n_err_cnt;
            r_out_vld    <= n_vld_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {3'b000, r_out_vld, r_out_err, r_out_idx, r_out_byte,
                          r_out_len, r_out_cmd};
    assign o_out_user  = {r_out_has, r_out_status};
    assign o_out_last  = r_out_last;

endmodule : sfr_datapath

// ===== rtl/sync_frame_receiver_unit.sv =====
// Results: an accepted byte's status result is loaded into the output register; for a good
// frame, the FETCH state reads the payload buffer and EMIT loads each payload result.
// Throughput: one byte per cycle while parsing and no result is stalled; a good frame then
// holds the input for a buffer read and an output load per payload byte, plus result stalls.
// Reset: i_rst_n is synchronous and active low; it clears the parser, the counters
// and the output valid flag, while the payload buffer keeps its contents.
// ============================================================================
// sync_frame_receiver_unit
// Receiver for AA 55 framed commands with an additive mod-256 checksum. Each
// accepted byte gives one status result; a good non-empty frame is instead
// reported as a run of payload results closed by tlast.
// ============================================================================
module sync_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Results out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_command, [14:8] frame_length, [22:15] payload_byte,
    // [28:23] payload_index, [44:29] error_count, [60:45] valid_count,
    // [63:61] zero.
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] has_byte
    output logic        m_axis_tlast    // last
);
    import sfr_pkg::*;

    // The controller owns the frame phases and the emission sequence; the
    // datapath holds everything that carries data, including the output
    // register that decouples the two sides of the block.
    t_sfr_cmd  w_cmd;
    t_sfr_stat w_stat;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // A stalled result must block the intake, or a status result would be lost.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input request taken while a result is stalled");

    // Every accepted frame produces either an empty-frame result or an emission.
    a_valid_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.valid_inc |-> (w_cmd.out_load_stat || w_cmd.emit_start))
        else $error("accepted frame without a result");

    // Only payload results may leave tlast low.
    a_nonlast_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser[2])
        else $error("non-final result without payload");

    // A frame is never counted as both rejected and accepted.
    a_count_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.err_inc && w_cmd.valid_inc))
        else $error("frame counted as both rejected and accepted");
`endif

endmodule : sync_frame_receiver_unit

// ===== test/sync_frame_receiver_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed byte receiver result checker
// Watches the byte requests and the result stream of the receiver. It keeps its
// own parser state, queues the results each accepted byte must cause, and
// compares every accepted result with the oldest queued one.
// ----------------------------------------------------------------------------
module sync_frame_receiver_result_checker #(
    parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_req_data,     // [7:0] rx_byte
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    // [7:0] frame_command, [14:8] frame_length, [22:15] payload_byte,
    // [28:23] payload_index, [44:29] error_count, [60:45] valid_count,
    // [63:61] zero.
    input  logic [63:0] i_res_data,
    input  logic [2:0]  i_res_user,     // [1:0] status, [2] has_byte
    input  logic        i_res_last,
    output int unsigned o_mismatches,
    output int unsigned o_pending
);
    import sfr_pkg::*;

    localparam int PAYLOAD_AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [2:0] {
        PARSE_HUNT,
        PARSE_SECOND,
        PARSE_COMMAND,
        PARSE_LENGTH,
        PARSE_PAYLOAD,
        PARSE_CHECK
    } t_parse_phase;

    typedef struct {
        t_status     status;
        logic [7:0]  command;
        logic [6:0]  length;
        logic        has_byte;
        logic [7:0]  data;
        logic [5:0]  index;
        logic        last;
        logic [15:0] rejected;
        logic [15:0] accepted;
    } t_frame_result;

    t_parse_phase  parse_phase;
    logic [7:0]    run_sum;
    logic [7:0]    held_cmd;
    logic [6:0]    held_len;
    logic [6:0]    fill_pos;
    logic [7:0]    payload_buf [0:MAX_PAYLOAD-1];
    logic [15:0]   rejected_total;
    logic [15:0]   accepted_total;
    t_frame_result expected_results [$];
    int unsigned   mismatch_count = 0;
    int unsigned   pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    task automatic push_result(input t_status status, input logic [7:0] command,
                               input logic [6:0] length, input logic has_byte,
                               input logic [7:0] data, input logic [5:0] index,
                               input logic last);
        t_frame_result item;
        item.status   = status;
        item.command  = command;
        item.length   = length;
        item.has_byte = has_byte;
        item.data     = data;
        item.index    = index;
        item.last     = last;
        item.rejected = rejected_total;
        item.accepted = accepted_total;
        expected_results.push_back(item);
    endtask

    // Advances the parser by one byte and queues the results it causes.
    task automatic parse_byte(input logic [7:0] rx);
        t_status status;
        logic    frame_emitted;
        int      k;
        status        = ST_BUSY;
        frame_emitted = 1'b0;
        case (parse_phase)
            PARSE_HUNT: begin
                if (rx == HDR_FIRST) begin
                    run_sum     = rx;
                    parse_phase = PARSE_SECOND;
                end
            end
            PARSE_SECOND: begin
                if (rx == HDR_SECOND) begin
                    run_sum     = run_sum + rx;
                    parse_phase = PARSE_COMMAND;
                end else if (rx == HDR_FIRST) begin
                    run_sum = HDR_FIRST;
                end else begin
                    run_sum     = 8'd0;
                    parse_phase = PARSE_HUNT;
                end
            end
            PARSE_COMMAND: begin
                held_cmd    = rx;
                run_sum     = run_sum + rx;
                parse_phase = PARSE_LENGTH;
            end
            PARSE_LENGTH: begin
                if (rx > 8'(MAX_PAYLOAD)) begin
                    parse_phase    = PARSE_HUNT;
                    rejected_total = rejected_total + 16'd1;
                    status         = ST_OVERFLOW;
                end else begin
                    held_len    = rx[6:0];
                    fill_pos    = 7'd0;
                    run_sum     = run_sum + rx;
                    parse_phase = (rx == 8'd0) ? PARSE_CHECK : PARSE_PAYLOAD;
                end
            end
            PARSE_PAYLOAD: begin
                if (fill_pos < 7'(MAX_PAYLOAD)) begin
                    payload_buf[fill_pos[PAYLOAD_AW-1:0]] = rx;
                end
                fill_pos = fill_pos + 7'd1;
                run_sum  = run_sum + rx;
                if (fill_pos >= held_len) begin
                    parse_phase = PARSE_CHECK;
                end
            end
            PARSE_CHECK: begin
                parse_phase = PARSE_HUNT;
                if (rx != run_sum) begin
                    rejected_total = rejected_total + 16'd1;
                    status         = ST_BADSUM;
                end else begin
                    accepted_total = accepted_total + 16'd1;
                    frame_emitted  = 1'b1;
                    if (held_len == 7'd0) begin
                        push_result(ST_OK, held_cmd, 7'd0, 1'b0, 8'd0, 6'd0, 1'b1);
                    end else begin
                        for (k = 0; k < int'(held_len); k++) begin
                            push_result(ST_OK, held_cmd, held_len, 1'b1,
                                        payload_buf[k[PAYLOAD_AW-1:0]],
                                        k[5:0], k == int'(held_len) - 1);
                        end
                    end
                end
            end
            default: begin
                parse_phase = PARSE_HUNT;
            end
        endcase
        if (!frame_emitted) begin
            push_result(status, 8'd0, 7'd0, 1'b0, 8'd0, 6'd0, 1'b1);
        end
    endtask

    task automatic check_result();
        t_frame_result want;
        logic          wrong;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: unexpected result: user %h data %h last %b",
                         $time, i_res_user, i_res_data, i_res_last);
            end
        end else begin
            want  = expected_results.pop_front();
            wrong = (i_res_user[1:0]    !== want.status)   ||
                    (i_res_user[2]      !== want.has_byte) ||
                    (i_res_data[7:0]    !== want.command)  ||
                    (i_res_data[14:8]   !== want.length)   ||
                    (i_res_data[22:15]  !== want.data)     ||
                    (i_res_data[28:23]  !== want.index)    ||
                    (i_res_data[44:29]  !== want.rejected) ||
                    (i_res_data[60:45]  !== want.accepted) ||
                    (i_res_data[63:61]  !== 3'b000)        ||
                    (i_res_last         !== want.last);
            if (wrong) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display({"%0t: result mismatch: expected status %0d has %0d cmd %h",
                              " len %0d byte %h idx %0d last %0d err %0d ok %0d"},
                             $time, want.status, want.has_byte, want.command,
                             want.length, want.data, want.index, want.last,
                             want.rejected, want.accepted);
                    $display({"%0t:                  actual   status %0d has %0d cmd %h",
                              " len %0d byte %h idx %0d last %0d err %0d ok %0d pad %b"},
                             $time, i_res_user[1:0], i_res_user[2], i_res_data[7:0],
                             i_res_data[14:8], i_res_data[22:15], i_res_data[28:23],
                             i_res_last, i_res_data[44:29], i_res_data[60:45],
                             i_res_data[63:61]);
                end
            end
        end
    endtask

    // A result is registered only after its byte is taken, so results are checked
    // before the byte accepted at the same edge is parsed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_phase    = PARSE_HUNT;
            run_sum        = 8'd0;
            held_cmd       = 8'd0;
            held_len       = 7'd0;
            fill_pos       = 7'd0;
            rejected_total = 16'd0;
            accepted_total = 16'd0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
            if (i_req_valid && i_req_ready) begin
                parse_byte(i_req_data);
            end
        end
        pending_count = expected_results.size();
    end

endmodule : sync_frame_receiver_result_checker

// ===== test/sync_frame_receiver_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed byte receiver testbench
// Feeds the receiver a directed set of frames and header corner cases, then a
// long random mix of good, corrupted, oversized and truncated frames with noise
// in between. A separate checker predicts and compares every result; this top
// only makes the byte stream, the result back-pressure and the verdict.
// ----------------------------------------------------------------------------
module sync_frame_receiver_unit_test;
    import sfr_pkg::*;

    localparam int MAX_PAYLOAD    = MAX_PAYLOAD_DEF;
    localparam int PAYLOAD_AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 320;
    // Cycles with no handshake on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles waited after the drain so that stray results are caught.
    localparam int DRAIN_CYCLES   = 10;

    // Back-pressure patterns on the result side.
    localparam int RX_ALWAYS   = 0;
    localparam int RX_MOSTLY   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_SPARSE   = 3;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data  = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    int unsigned mismatches;
    int unsigned pending;

    int unsigned sent_count  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_mode  = RX_ALWAYS;
    int unsigned stall_span  = 0;
    int unsigned stall_tick  = 0;

    // Payload of the next frame that send_frame puts on the wire.
    logic [7:0]  frame_payload [0:MAX_PAYLOAD-1];

    sync_frame_receiver_unit #(
        .MAX_PAYLOAD   (MAX_PAYLOAD)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),   // [7:0] rx_byte
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),   // see the port list of the block for the layout
        .m_axis_tuser  (m_user),   // [1:0] status, [2] has_byte
        .m_axis_tlast  (m_last)
    );

    sync_frame_receiver_result_checker #(
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_valid),
        .i_req_ready  (s_ready),
        .i_req_data   (s_data),
        .i_res_valid  (m_valid),
        .i_res_ready  (m_ready),
        .i_res_data   (m_data),
        .i_res_user   (m_user),
        .i_res_last   (m_last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 20 ns clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The result side draws a new pattern whenever its span runs out: always
    // ready, mostly ready, a fixed duty cycle, or only rarely ready. The
    // always-ready spans give stretches with no stalls at all.
    always @(negedge clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
            stall_span = $urandom_range(16, 96);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            RX_ALWAYS:   m_ready <= 1'b1;
            RX_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_ready <= ((stall_tick % 5) < 2);
            default:     m_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Watchdog: any handshake on either side restarts the count. Reset
    // counts as activity so the start of the run is never flagged.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Puts one byte request on the input side and waits until it is taken.
    // The sender works in bursts; when a burst runs out, tvalid drops for a
    // random gap with junk on tdata, and a new burst length is drawn.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            s_data  <= 8'($urandom_range(0, 255));
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        burst_left--;
        do begin
            @(posedge clk);
        end while (!s_ready);
        sent_count++;
    endtask

    // Sends a whole frame: header, command and length, then the payload held
    // in frame_payload and the checksum plus sum_skew. A nonzero skew breaks
    // the checksum. An oversized length ends the frame right after the length
    // byte, since the receiver drops back to hunting there.
    task automatic send_frame(input logic [7:0] command, input logic [7:0] length,
                              input logic [7:0] sum_skew);
        logic [7:0] sum;
        int         i;
        sum = HDR_FIRST + HDR_SECOND + command + length;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(command);
        send_byte(length);
        if (length <= 8'(MAX_PAYLOAD)) begin
            for (i = 0; i < int'(length); i++) begin
                send_byte(frame_payload[i[PAYLOAD_AW-1:0]]);
                sum = sum + frame_payload[i[PAYLOAD_AW-1:0]];
            end
            send_byte(sum + sum_skew);
        end
    endtask

    // Holds the input side idle until every queued result has come out.
    task automatic hold_until_drained();
        @(negedge clk);
        s_valid <= 1'b0;
        wait (pending == 0);
    endtask

    initial begin
        int unsigned random_base;
        int unsigned pick;
        int unsigned length;
        int unsigned extra;
        int unsigned i;
        logic        mid_hold_done;

        mid_hold_done = 1'b0;

        // Single synchronous reset at the start of the run.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- Directed part ----------------
        // The extremes of the byte while hunting: both must give busy.
        send_byte(8'h00);
        send_byte(8'hFF);
        // A first header byte followed by some other byte drops back to
        // hunting.
        send_byte(HDR_FIRST);
        send_byte(8'h00);
        // A repeated first header byte restarts the header; the frame that
        // follows is a good empty one, so it gives a single ok result.
        send_byte(HDR_FIRST);
        send_frame(8'hFF, 8'd0, 8'd0);
        // A length one above the largest payload is an overflow.
        send_frame(8'h00, 8'(MAX_PAYLOAD + 1), 8'd0);
        // A checksum mismatch, directly followed by a good one-byte frame
        // whose payload is itself a header byte.
        frame_payload[0] = 8'h00;
        frame_payload[1] = 8'hFF;
        send_frame(8'h10, 8'd2, 8'd1);
        frame_payload[0] = HDR_FIRST;
        send_frame(8'h7E, 8'd1, 8'd0);

        // The sender waits here until the receiver has said all it has to say.
        hold_until_drained();

        // ---------------- Random part ----------------
        random_base = sent_count;
        while (sent_count - random_base < RANDOM_ITEMS) begin
            if (!mid_hold_done && sent_count - random_base >= RANDOM_ITEMS / 2) begin
                hold_until_drained();
                mid_hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // Well-formed frame with random content. Most payloads are
                // short; a few are long, and now and then exactly full size.
                // About one in ten carries a bad checksum.
                if ($urandom_range(0, 19) == 0) begin
                    length = MAX_PAYLOAD;
                end else if ($urandom_range(0, 9) == 0) begin
                    length = $urandom_range(0, MAX_PAYLOAD);
                end else begin
                    length = $urandom_range(0, 6);
                end
                for (i = 0; i < length; i++) begin
                    frame_payload[i[PAYLOAD_AW-1:0]] = 8'($urandom_range(0, 255));
                end
                send_frame(8'($urandom_range(0, 255)), 8'(length),
                           8'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : 0));
            end else if (pick < 80) begin
                // Oversized length, either just above the limit or anywhere up
                // to the top of the byte range.
                length = $urandom_range(0, 1) ? MAX_PAYLOAD + 1
                                              : $urandom_range(MAX_PAYLOAD + 1, 255);
                send_frame(8'($urandom_range(0, 255)), 8'(length), 8'd0);
            end else if (pick < 85) begin
                // Broken header: runs of first header bytes, then any byte.
                extra = $urandom_range(1, 3);
                repeat (extra) send_byte(HDR_FIRST);
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                // Truncated frame: the following bytes get swallowed as the
                // rest of its payload and its checksum.
                length = $urandom_range(1, 8);
                send_byte(HDR_FIRST);
                send_byte(HDR_SECOND);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'(length));
                extra = $urandom_range(0, length - 1);
                repeat (extra) send_byte(8'($urandom_range(0, 255)));
            end else begin
                // Line noise.
                extra = $urandom_range(1, 4);
                repeat (extra) send_byte(8'($urandom_range(0, 255)));
            end
        end

        // ---------------- End of run ----------------
        @(negedge clk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule : sync_frame_receiver_unit_test

// ===== sync_frame_receiver_unit.f =====
rtl/sfr_pkg.sv
rtl/sfr_ctrl.sv
rtl/sfr_datapath.sv
rtl/sync_frame_receiver_unit.sv
test/sync_frame_receiver_result_checker.sv
test/sync_frame_receiver_unit_test.sv
